[rtl/core/ucdw_pkg.sv]
// ----------------------------------------------------------------------------
// ucdw_pkg
// shared types and constants of the configuration descriptor walker
// ----------------------------------------------------------------------------
`default_nettype none

package ucdw_pkg;

    localparam int unsigned MaxInterfaces = 32;
    localparam int unsigned QueueDepth    = 4;

    localparam logic [7:0] HeaderMin   = 8'd9;
    localparam logic [7:0] DescMin     = 8'd2;
    localparam logic [7:0] EpMin       = 8'd7;
    localparam logic [7:0] IntfMin     = 8'd9;
    localparam logic [7:0] TypeConfig  = 8'd2;
    localparam logic [7:0] TypeIntf    = 8'd4;
    localparam logic [7:0] TypeEp      = 8'd5;

    localparam logic [3:0] RoleCfg       = 4'd0;
    localparam logic [3:0] RoleIntf      = 4'd1;
    localparam logic [3:0] RoleEp        = 4'd2;
    localparam logic [3:0] RoleCfgExtra  = 4'd3;
    localparam logic [3:0] RoleIntfExtra = 4'd4;
    localparam logic [3:0] RoleEpExtra   = 4'd5;
    localparam logic [3:0] RoleSkip      = 4'd6;
    localparam logic [3:0] RoleTrail     = 4'd7;
    localparam logic [3:0] RoleReject    = 4'd8;
    localparam logic [3:0] RolePend      = 4'd9;

    // one result beat
    typedef struct packed {
        logic [7:0] byte_value;
        logic [3:0] byte_role;
        logic [7:0] interface_number;
        logic [7:0] alternate_index;
        logic [7:0] endpoint_slot;
        logic [7:0] offset_in_descriptor;
        logic       config_end;
        logic       run_last;
    } t_result;

    // work for the back end: up to three beats from one input byte
    typedef struct packed {
        logic [1:0] count;       // beats minus one
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_burst;

endpackage

`default_nettype wire

[rtl/core/ucdw_front.sv]
// ----------------------------------------------------------------------------
// ucdw_front
// walks the descriptor stream and classifies each byte into a burst
// ----------------------------------------------------------------------------
`default_nettype none

module ucdw_front
    import ucdw_pkg::*;
#(
    parameter int unsigned MAX_INTERFACES = MaxInterfaces
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire logic [7:0] i_data_byte,
    output t_burst      o_burst
);

    localparam int unsigned IW = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;

    typedef enum logic [3:0] {
        PH_HEAD   = 4'b0001,
        PH_WALK   = 4'b0010,
        PH_TRAIL  = 4'b0100,
        PH_REJECT = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_left, n_left;
    logic        r_bad, n_bad;
    logic [7:0]  r_hlen, n_hlen;
    logic [7:0]  r_itot, n_itot;
    logic [7:0]  r_off, n_off;
    logic [7:0]  r_dlen, n_dlen;
    logic [3:0]  r_drole, n_drole;
    logic [7:0]  r_held0, n_held0, r_held1, n_held1;
    logic [7:0]  r_cint, n_cint, r_calt, n_calt, r_cep, n_cep;
    logic        r_aval, n_aval, r_eval, n_eval;
    logic [7:0]  r_edecl, n_edecl, r_efill, n_efill;
    logic [7:0]  r_alt [MAX_INTERFACES];
    logic        r_altv [MAX_INTERFACES];
    logic        clr_alt, inc_alt;
    logic [IW-1:0] alt_idx;
    logic [7:0]  alt_rd;
    logic        ended;
    logic [16:0] total;
    t_burst      burst;
    t_result     rr [3];
    logic [1:0]  nres;

    assign alt_idx = i_data_byte[IW-1:0];
    assign alt_rd  = r_altv[alt_idx] ? r_alt[alt_idx] : 8'd0;

    // build one result from the owner state as it stands after this byte
    function automatic t_result mk(input logic [7:0] b, input logic [3:0] role,
                                   input logic [7:0] off, input logic [7:0] ci,
                                   input logic [7:0] ca, input logic [7:0] ce);
        t_result r;
        logic hi, he;
        hi = (role == RoleIntf) || (role == RoleEp) ||
             (role == RoleIntfExtra) || (role == RoleEpExtra);
        he = (role == RoleEp) || (role == RoleEpExtra);
        r.byte_value           = b;
        r.byte_role            = role;
        r.interface_number     = hi ? ci : 8'd0;
        r.alternate_index      = hi ? ca : 8'd0;
        r.endpoint_slot        = he ? ce : 8'd0;
        r.offset_in_descriptor = ((role == RoleTrail) || (role == RoleReject)) ? 8'd0 : off;
        r.config_end           = 1'b0;
        r.run_last             = 1'b0;
        return r;
    endfunction

    // walk step
    always_comb begin
        logic [3:0] role;
        logic [7:0] k;
        n_phase = r_phase; n_left = r_left; n_bad = r_bad; n_hlen = r_hlen;
        n_itot = r_itot; n_off = r_off; n_dlen = r_dlen; n_drole = r_drole;
        n_held0 = r_held0; n_held1 = r_held1; n_cint = r_cint; n_calt = r_calt;
        n_cep = r_cep; n_aval = r_aval; n_eval = r_eval; n_edecl = r_edecl;
        n_efill = r_efill;
        clr_alt = 1'b0; inc_alt = 1'b0; ended = 1'b0;
        nres = 2'd0;
        role = RoleCfg;
        k = r_off;
        total = 17'd0;
        rr[0] = '0; rr[1] = '0; rr[2] = '0;
        unique case (r_phase)
            PH_HEAD: begin
                if (k == 8'd0) begin
                    n_hlen = i_data_byte; n_bad = 1'b0; n_itot = 8'd0;
                    clr_alt = 1'b1; n_aval = 1'b0; n_eval = 1'b0;
                    n_cint = 8'd0; n_calt = 8'd0; n_cep = 8'd0;
                    n_edecl = 8'd0; n_efill = 8'd0;
                    n_held0 = i_data_byte; n_off = 8'd1;
                end else begin
                    if (k == 8'd1) begin
                        n_bad = (i_data_byte != TypeConfig) || (r_hlen < HeaderMin);
                        role = n_bad ? RoleReject : RoleCfg;
                        rr[0] = mk(r_held0, role, 8'd0, 8'd0, 8'd0, 8'd0);
                        rr[1] = mk(i_data_byte, role, 8'd1, 8'd0, 8'd0, 8'd0);
                        nres = 2'd2;
                    end else begin
                        role = r_bad ? RoleReject : RoleCfg;
                        if (k == 8'd2) n_held1 = i_data_byte;
                        if (k == 8'd3) begin
                            total = {1'b0, i_data_byte, r_held1};
                            if (total < 17'd9) total = 17'd9;
                            n_left = 16'(total - 17'd4);
                        end
                        if (k == 8'd4) n_itot = i_data_byte;
                        rr[0] = mk(i_data_byte, role, k, 8'd0, 8'd0, 8'd0);
                        nres = 2'd1;
                        if (k >= 8'd4) begin
                            n_left = r_left - 16'd1;
                            if (n_left == 16'd0) ended = 1'b1;
                        end
                    end
                    n_off = k + 8'd1;
                    if (!ended) begin
                        if (k == 8'd3 && r_bad) begin
                            n_phase = PH_REJECT; n_off = 8'd0;
                        end else if (!n_bad && k >= 8'd8 && n_off >= r_hlen) begin
                            n_phase = PH_WALK; n_off = 8'd0;
                        end
                    end
                end
            end
            PH_WALK: begin
                if (k == 8'd0) begin
                    if (r_left < 16'd2 || i_data_byte < DescMin ||
                        {8'd0, i_data_byte} > r_left) begin
                        n_phase = PH_TRAIL;
                        rr[0] = mk(i_data_byte, RoleTrail, 8'd0, 8'd0, 8'd0, 8'd0);
                        nres = 2'd1;
                    end else begin
                        n_dlen = i_data_byte; n_held0 = i_data_byte; n_off = 8'd1;
                    end
                end else begin
                    if (k == 8'd1) begin
                        if (i_data_byte == TypeIntf) begin
                            if (r_dlen < IntfMin) n_drole = RoleSkip;
                            else begin
                                n_drole = RolePend; n_held1 = i_data_byte;
                            end
                        end else if (i_data_byte == TypeEp) begin
                            if (r_dlen < EpMin || !r_aval || r_efill >= r_edecl)
                                n_drole = RoleSkip;
                            else begin
                                n_cep = r_efill; n_efill = r_efill + 8'd1;
                                n_eval = 1'b1; n_drole = RoleEp;
                            end
                        end else begin
                            n_drole = r_eval ? RoleEpExtra :
                                      (r_aval ? RoleIntfExtra : RoleCfgExtra);
                        end
                        if (n_drole != RolePend) begin
                            rr[0] = mk(r_held0, n_drole, 8'd0, n_cint, n_calt, n_cep);
                            rr[1] = mk(i_data_byte, n_drole, 8'd1, n_cint, n_calt, n_cep);
                            nres = 2'd2;
                        end
                    end else if (k == 8'd2 && r_drole == RolePend) begin
                        if (i_data_byte < r_itot &&
                            {24'd0, i_data_byte} < 32'(MAX_INTERFACES) &&
                            alt_rd != 8'd255) begin
                            n_cint = i_data_byte; n_calt = alt_rd; inc_alt = 1'b1;
                            n_aval = 1'b1; n_eval = 1'b0; n_cep = 8'd0;
                            n_edecl = 8'd0; n_efill = 8'd0; n_drole = RoleIntf;
                        end else n_drole = RoleSkip;
                        rr[0] = mk(r_held0, n_drole, 8'd0, n_cint, n_calt, n_cep);
                        rr[1] = mk(r_held1, n_drole, 8'd1, n_cint, n_calt, n_cep);
                        rr[2] = mk(i_data_byte, n_drole, 8'd2, n_cint, n_calt, n_cep);
                        nres = 2'd3;
                    end else begin
                        if (k == 8'd4 && r_drole == RoleIntf) n_edecl = i_data_byte;
                        rr[0] = mk(i_data_byte, r_drole, k, n_cint, n_calt, n_cep);
                        nres = 2'd1;
                    end
                    n_off = k + 8'd1;
                    if (n_off >= r_dlen) n_off = 8'd0;
                end
                n_left = r_left - 16'd1;
                if (n_left == 16'd0) ended = 1'b1;
            end
            PH_TRAIL, PH_REJECT: begin
                rr[0] = mk(i_data_byte, (r_phase == PH_TRAIL) ? RoleTrail : RoleReject,
                           8'd0, 8'd0, 8'd0, 8'd0);
                nres = 2'd1;
                n_left = r_left - 16'd1;
                if (n_left == 16'd0) ended = 1'b1;
            end
            default: n_phase = PH_HEAD;
        endcase
        if (ended) begin
            n_phase = PH_HEAD; n_off = 8'd0; n_left = 16'd0;
        end
        // flag the last beat of this byte
        burst.count = nres - 2'd1;
        burst.r0 = rr[0]; burst.r1 = rr[1]; burst.r2 = rr[2];
        case (nres)
            2'd1: begin burst.r0.run_last = 1'b1; burst.r0.config_end = ended; end
            2'd2: begin burst.r1.run_last = 1'b1; burst.r1.config_end = ended; end
            2'd3: begin burst.r2.run_last = 1'b1; burst.r2.config_end = ended; end
            default: ;
        endcase
    end

    // burst out, valid only when the byte produced beats
    always_comb begin
        o_burst = burst;
        if (!i_valid || nres == 2'd0) o_burst.count = 2'd3;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEAD; r_left <= '0; r_bad <= 1'b0; r_hlen <= '0;
            r_itot <= '0; r_off <= '0; r_dlen <= '0; r_drole <= '0;
            r_held0 <= '0; r_held1 <= '0; r_cint <= '0; r_calt <= '0; r_cep <= '0;
            r_aval <= 1'b0; r_eval <= 1'b0; r_edecl <= '0; r_efill <= '0;
        end else if (i_valid) begin
            r_phase <= n_phase; r_left <= n_left; r_bad <= n_bad; r_hlen <= n_hlen;
            r_itot <= n_itot; r_off <= n_off; r_dlen <= n_dlen; r_drole <= n_drole;
            r_held0 <= n_held0; r_held1 <= n_held1; r_cint <= n_cint;
            r_calt <= n_calt; r_cep <= n_cep; r_aval <= n_aval; r_eval <= n_eval;
            r_edecl <= n_edecl; r_efill <= n_efill;
        end
    end

    // alternate counts, valid bits cleared at every header
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_INTERFACES; i++) r_altv[i] <= 1'b0;
        end else if (i_valid && clr_alt) begin
            for (int i = 0; i < MAX_INTERFACES; i++) r_altv[i] <= 1'b0;
        end else if (i_valid && inc_alt) begin
            r_altv[alt_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && inc_alt) r_alt[alt_idx] <= alt_rd + 8'd1;
    end

endmodule

`default_nettype wire

[rtl/core/ucdw_back.sv]
// ----------------------------------------------------------------------------
// ucdw_back
// burst queue and beat-by-beat result delivery
// ----------------------------------------------------------------------------
`default_nettype none

module ucdw_back
    import ucdw_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_burst i_burst,
    output logic        o_full,
    output logic        o_empty,
    input  wire logic   i_pop,
    output t_result     o_result
);

    localparam int unsigned AW = $clog2(QueueDepth);

    t_burst        r_q [QueueDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic [1:0]    r_beat;
    logic          wr, rd, last;
    t_burst        head;

    // a push of count 3 means the byte gave no beats
    assign wr   = i_push && !o_full && (i_burst.count != 2'd3);
    assign head = r_q[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (AW+1)'(QueueDepth));
    assign last = (r_beat == head.count);
    assign rd   = i_pop && !o_empty && last;

    always_comb begin
        case (r_beat)
            2'd0:    o_result = head.r0;
            2'd1:    o_result = head.r1;
            default: o_result = head.r2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= i_burst;
    end

    // pointers and beat counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_beat <= '0;
        end else begin
            if (wr) r_wp <= r_wp + AW'(1);
            if (rd) r_rp <= r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
            if (i_pop && !o_empty) r_beat <= last ? 2'd0 : r_beat + 2'd1;
        end
    end

endmodule

`default_nettype wire

[rtl/core/usb_config_descriptor_walker.sv]
// ----------------------------------------------------------------------------
// usb_config_descriptor_walker
// tags each byte of a configuration descriptor stream with its owner
// ----------------------------------------------------------------------------
// channel  dir  handshake      beat
// input    in   i_push/o_full  one stream byte
// result   out  o_empty/i_pop  one tagged byte
//
// the front end classifies one byte per cycle while o_full is low and queues
// up to three beats per byte as one burst; the back end hands out one beat per
// cycle while i_pop is high, and a byte gives zero to three beats, one on average
// as every byte is tagged once; its beats are queued when the byte is accepted
// reset is synchronous, active low; it clears the walk and the queue
// full rises when the four-entry burst queue is taken
// ----------------------------------------------------------------------------
`default_nettype none

module usb_config_descriptor_walker
    import ucdw_pkg::*;
#(
    parameter int unsigned MAX_INTERFACES = MaxInterfaces
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic [7:0] i_data_byte,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_byte_value,
    output logic [3:0]      o_byte_role,
    output logic [7:0]      o_interface_number,
    output logic [7:0]      o_alternate_index,
    output logic [7:0]      o_endpoint_slot,
    output logic [7:0]      o_offset_in_descriptor,
    output logic            o_config_end,
    output logic            o_run_last
);

    t_burst  burst;
    t_result res;
    logic    acc;

    assign acc = i_push && !o_full;

    ucdw_front #(.MAX_INTERFACES(MAX_INTERFACES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc),
        .i_data_byte(i_data_byte), .o_burst(burst)
    );

    ucdw_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(acc), .i_burst(burst),
        .o_full(o_full), .o_empty(o_empty), .i_pop(i_pop), .o_result(res)
    );

    assign o_byte_value           = res.byte_value;
    assign o_byte_role            = res.byte_role;
    assign o_interface_number     = res.interface_number;
    assign o_alternate_index      = res.alternate_index;
    assign o_endpoint_slot        = res.endpoint_slot;
    assign o_offset_in_descriptor = res.offset_in_descriptor;
    assign o_config_end           = res.config_end;
    assign o_run_last             = res.run_last;

endmodule

`default_nettype wire

[tb/sv/tb_usb_config_descriptor_walker.sv]
// ----------------------------------------------------------------------------
// tb_usb_config_descriptor_walker
// self-checking bench for the configuration descriptor walker
// ----------------------------------------------------------------------------
// streams directed and random configuration descriptors into the walker,
// predicts the tag of every byte with a behavioural walker of its own and
// compares each result beat, field by field, with the oldest prediction;
// the sender bursts with gaps, the receiver stalls on a rotating pattern
// and once holds off long enough for the input side to fill and stall
// ----------------------------------------------------------------------------
`default_nettype none

module tb_usb_config_descriptor_walker
    import ucdw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 400000;

    typedef enum logic [3:0] {
        WALK_HDR    = 4'b0001,
        WALK_DESC   = 4'b0010,
        WALK_TRAIL  = 4'b0100,
        WALK_REJECT = 4'b1000
    } t_walk_phase;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic [7:0] i_data_byte;
    logic       o_empty;
    logic       i_pop;
    logic [7:0] o_byte_value;
    logic [3:0] o_byte_role;
    logic [7:0] o_interface_number;
    logic [7:0] o_alternate_index;
    logic [7:0] o_endpoint_slot;
    logic [7:0] o_offset_in_descriptor;
    logic       o_config_end;
    logic       o_run_last;

    usb_config_descriptor_walker dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_push                 (i_push),
        .o_full                 (o_full),
        .i_data_byte            (i_data_byte),
        .o_empty                (o_empty),
        .i_pop                  (i_pop),
        .o_byte_value           (o_byte_value),
        .o_byte_role            (o_byte_role),
        .o_interface_number     (o_interface_number),
        .o_alternate_index      (o_alternate_index),
        .o_endpoint_slot        (o_endpoint_slot),
        .o_offset_in_descriptor (o_offset_in_descriptor),
        .o_config_end           (o_config_end),
        .o_run_last             (o_run_last)
    );

    logic [7:0] stream_bytes[$];
    t_result    expected_tags[$];
    t_result    step_tags[$];
    int         fail_count = 0;
    int         cycle_count = 0;

    // walker state kept by the bench
    t_walk_phase phase_q = WALK_HDR;
    logic [15:0] cfg_left = '0;
    logic        hdr_bad = 1'b0;
    logic [7:0]  hdr_len = '0;
    logic [7:0]  intf_total = '0;
    logic [7:0]  desc_pos = '0;
    logic [7:0]  desc_len = '0;
    logic [3:0]  desc_owner = '0;
    logic [7:0]  held[2] = '{default: '0};
    logic [7:0]  alt_count[MaxInterfaces] = '{default: '0};
    logic [7:0]  cur_intf = '0;
    logic [7:0]  cur_alt = '0;
    logic        alt_ok = 1'b0;
    logic [7:0]  ep_declared = '0;
    logic [7:0]  ep_filled = '0;
    logic        ep_ok = 1'b0;
    logic [7:0]  cur_ep = '0;

    // clock and reset
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic void tag_byte(logic [7:0] b, logic [3:0] role, logic [7:0] offs);
        t_result r;
        logic    has_intf;
        logic    has_ep;
        has_intf = (role == RoleIntf || role == RoleEp || role == RoleIntfExtra
                    || role == RoleEpExtra);
        has_ep = (role == RoleEp || role == RoleEpExtra);
        r.byte_value = b;
        r.byte_role = role;
        r.interface_number = has_intf ? cur_intf : 8'd0;
        r.alternate_index = has_intf ? cur_alt : 8'd0;
        r.endpoint_slot = has_ep ? cur_ep : 8'd0;
        r.offset_in_descriptor = (role == RoleTrail || role == RoleReject) ? 8'd0 : offs;
        r.config_end = 1'b0;
        r.run_last = 1'b0;
        step_tags.push_back(r);
    endfunction

    function automatic logic [3:0] extra_role();
        if (ep_ok) return RoleEpExtra;
        if (alt_ok) return RoleIntfExtra;
        return RoleCfgExtra;
    endfunction

    // header bytes; returns 1 when the configuration ends here
    function automatic logic header_byte(logic [7:0] b);
        logic [7:0]  k;
        logic [3:0]  role;
        logic [15:0] total;
        logic        ended;
        k = desc_pos;
        ended = 1'b0;
        if (k == 8'd0) begin
            hdr_len = b;
            hdr_bad = 1'b0;
            intf_total = '0;
            alt_count = '{default: '0};
            alt_ok = 1'b0;
            ep_ok = 1'b0;
            cur_intf = '0;
            cur_alt = '0;
            cur_ep = '0;
            ep_declared = '0;
            ep_filled = '0;
            held[0] = b;
            desc_pos = 8'd1;
            return 1'b0;
        end
        if (k == 8'd1) begin
            hdr_bad = (b != TypeConfig || hdr_len < HeaderMin);
            role = hdr_bad ? RoleReject : RoleCfg;
            tag_byte(held[0], role, 8'd0);
            tag_byte(b, role, 8'd1);
        end else begin
            role = hdr_bad ? RoleReject : RoleCfg;
            if (k == 8'd2) held[1] = b;
            if (k == 8'd3) begin
                total = {b, held[1]};
                if (total < 16'd9) total = 16'd9;
                cfg_left = total - 16'd4;
            end
            if (k == 8'd4) intf_total = b;
            tag_byte(b, role, k);
            if (k >= 8'd4) begin
                cfg_left = cfg_left - 16'd1;
                if (cfg_left == 16'd0) ended = 1'b1;
            end
        end
        desc_pos = k + 8'd1;
        if (ended) return 1'b1;
        if (k == 8'd3 && hdr_bad) begin
            phase_q = WALK_REJECT;
            desc_pos = '0;
        end else if (!hdr_bad && k >= 8'd8 && desc_pos >= hdr_len) begin
            phase_q = WALK_DESC;
            desc_pos = '0;
        end
        return 1'b0;
    endfunction

    // descriptor bytes after the header
    function automatic void descriptor_byte(logic [7:0] b);
        logic [7:0] k;
        k = desc_pos;
        if (k == 8'd0) begin
            if (cfg_left < 16'd2 || b < DescMin || 16'(b) > cfg_left) begin
                phase_q = WALK_TRAIL;
                tag_byte(b, RoleTrail, 8'd0);
                return;
            end
            desc_len = b;
            held[0] = b;
            desc_pos = 8'd1;
            return;
        end
        if (k == 8'd1) begin
            if (b == TypeIntf) begin
                if (desc_len < IntfMin) begin
                    desc_owner = RoleSkip;
                end else begin
                    desc_owner = RolePend;
                    held[1] = b;
                end
            end else if (b == TypeEp) begin
                if (desc_len < EpMin || !alt_ok || ep_filled >= ep_declared) begin
                    desc_owner = RoleSkip;
                end else begin
                    cur_ep = ep_filled;
                    ep_filled = ep_filled + 8'd1;
                    ep_ok = 1'b1;
                    desc_owner = RoleEp;
                end
            end else begin
                desc_owner = extra_role();
            end
            if (desc_owner != RolePend) begin
                tag_byte(held[0], desc_owner, 8'd0);
                tag_byte(b, desc_owner, 8'd1);
            end
        end else if (k == 8'd2 && desc_owner == RolePend) begin
            if (b < intf_total && b < MaxInterfaces && alt_count[b[4:0]] < 8'd255) begin
                cur_intf = b;
                cur_alt = alt_count[b[4:0]];
                alt_count[b[4:0]] = alt_count[b[4:0]] + 8'd1;
                alt_ok = 1'b1;
                ep_ok = 1'b0;
                cur_ep = '0;
                ep_declared = '0;
                ep_filled = '0;
                desc_owner = RoleIntf;
            end else begin
                desc_owner = RoleSkip;
            end
            tag_byte(held[0], desc_owner, 8'd0);
            tag_byte(held[1], desc_owner, 8'd1);
            tag_byte(b, desc_owner, 8'd2);
        end else begin
            if (k == 8'd4 && desc_owner == RoleIntf) ep_declared = b;
            tag_byte(b, desc_owner, k);
        end
        desc_pos = k + 8'd1;
        if (desc_pos >= desc_len) desc_pos = '0;
    endfunction

    // expected tags for one accepted stream byte
    function automatic void predict_tags(logic [7:0] b);
        logic ended;
        step_tags.delete();
        ended = 1'b0;
        if (phase_q == WALK_HDR) begin
            ended = header_byte(b);
        end else begin
            if (phase_q == WALK_DESC) descriptor_byte(b);
            else tag_byte(b, (phase_q == WALK_TRAIL) ? RoleTrail : RoleReject, 8'd0);
            cfg_left = cfg_left - 16'd1;
            if (cfg_left == 16'd0) ended = 1'b1;
        end
        if (ended) begin
            phase_q = WALK_HDR;
            desc_pos = '0;
            cfg_left = '0;
        end
        if (step_tags.size() > 0) begin
            step_tags[step_tags.size()-1].run_last = 1'b1;
            if (ended) step_tags[step_tags.size()-1].config_end = 1'b1;
        end
        foreach (step_tags[i]) expected_tags.push_back(step_tags[i]);
    endfunction

    // stimulus building
    logic [7:0] body[$];

    function automatic void add_intf(logic [7:0] num, logic [7:0] n_ep, int len = 9);
        body.push_back(8'(len));
        body.push_back(TypeIntf);
        body.push_back(num);
        for (int i = 3; i < len; i++) body.push_back(i == 4 ? n_ep : 8'($urandom));
    endfunction

    function automatic void add_desc(logic [7:0] kind, int len);
        body.push_back(8'(len));
        body.push_back(kind);
        for (int i = 2; i < len; i++) body.push_back(8'($urandom));
    endfunction

    // header then body; total of -1 means the exact length
    function automatic void add_config(int hlen, logic [7:0] kind, logic [7:0] n_intf,
                                       int total = -1);
        int t;
        t = (total < 0) ? hlen + body.size() : total;
        stream_bytes.push_back(8'(hlen));
        stream_bytes.push_back(kind);
        stream_bytes.push_back(t[7:0]);
        stream_bytes.push_back(t[15:8]);
        stream_bytes.push_back(n_intf);
        for (int i = 5; i < hlen; i++) stream_bytes.push_back(8'($urandom));
        foreach (body[i]) stream_bytes.push_back(body[i]);
        body.delete();
    endfunction

    function automatic void add_random_config();
        int n_intf;
        int n_desc;
        int sel;
        int hlen;
        logic [7:0] kind;
        n_intf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 4);
        n_desc = $urandom_range(1, 8);
        for (int d = 0; d < n_desc; d++) begin
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
                add_intf(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 4)),
                         8'($urandom_range(0, 4)), ($urandom_range(0, 9) == 0) ?
                         $urandom_range(2, 12) : 9);
            end else if (sel < 7) begin
                add_desc(TypeEp, ($urandom_range(0, 9) == 0) ? $urandom_range(2, 9) : 7);
            end else if (sel < 9) begin
                add_desc(8'($urandom), $urandom_range(2, 10));
            end else begin
                // junk length field, usually stops the walk
                body.push_back(8'($urandom_range(0, 3)));
            end
        end
        hlen = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : 9;
        kind = ($urandom_range(0, 9) == 0) ? 8'($urandom) : TypeConfig;
        if ($urandom_range(0, 7) == 0)
            add_config(hlen, kind, 8'(n_intf), $urandom_range(0, hlen + body.size() + 10));
        else
            add_config(hlen, kind, 8'(n_intf));
        // occasional noise between configurations
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom));
    endfunction

    initial begin
        // interfaces, endpoints, extras of each owner, no slot, unknown and short ones
        add_desc(8'h21, 3);
        add_desc(TypeEp, 7);
        add_intf(8'd0, 8'd2);
        add_desc(8'h24, 4);
        add_desc(TypeEp, 7);
        add_desc(TypeEp, 7);
        add_desc(8'hff, 2);
        add_desc(TypeEp, 7);
        add_intf(8'd1, 8'd0);
        add_intf(8'd0, 8'd1);
        add_intf(8'd5, 8'd1);
        add_intf(8'd40, 8'd1);
        add_intf(8'd0, 8'd1, 5);
        add_desc(TypeEp, 4);
        add_config(9, TypeConfig, 8'd255);
        // rejected headers: wrong type, too short a length
        add_config(9, 8'd3, 8'd0, 12);
        add_config(8, TypeConfig, 8'd0, 10);
        // short total: bare header, then long header
        add_config(9, TypeConfig, 8'd1, 0);
        add_config(12, TypeConfig, 8'd1);
        // walk stops: length under two, length past the end
        add_desc(8'h30, 3);
        body.push_back(8'd1);
        repeat (3) body.push_back(8'd0);
        add_config(9, TypeConfig, 8'd1);
        add_desc(8'h30, 12);
        add_config(9, TypeConfig, 8'd1, 15);
        while (stream_bytes.size() < 180) add_random_config();
    end

    // driver: bursts of bytes separated by random gaps
    int burst_left = 4;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
            i_data_byte <= '0;
        end else if (!(i_push && o_full)) begin
            if (i_push) begin
                predict_tags(i_data_byte);
                void'(stream_bytes.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                i_push <= 1'b0;
            end else if (stream_bytes.size() > 0) begin
                i_push <= 1'b1;
                i_data_byte <= stream_bytes[0];
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // monitor: rotating stall pattern plus one long hold-off
    int pop_mode = 0;
    int mode_cycles = 0;
    int hold_left = 0;
    int beats_seen = 0;
    logic hold_done = 1'b0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                beats_seen++;
                if (expected_tags.size() == 0) begin
                    $error("unexpected beat: byte_value %0h role %0d", o_byte_value,
                           o_byte_role);
                    fail_count++;
                end else begin
                    want = expected_tags.pop_front();
                    if (o_byte_value !== want.byte_value) begin
                        $error("byte_value: expected %0h actual %0h", want.byte_value,
                               o_byte_value);
                        fail_count++;
                    end
                    if (o_byte_role !== want.byte_role) begin
                        $error("byte_role: expected %0d actual %0d", want.byte_role,
                               o_byte_role);
                        fail_count++;
                    end
                    if (o_interface_number !== want.interface_number) begin
                        $error("interface_number: expected %0d actual %0d",
                               want.interface_number, o_interface_number);
                        fail_count++;
                    end
                    if (o_alternate_index !== want.alternate_index) begin
                        $error("alternate_index: expected %0d actual %0d",
                               want.alternate_index, o_alternate_index);
                        fail_count++;
                    end
                    if (o_endpoint_slot !== want.endpoint_slot) begin
                        $error("endpoint_slot: expected %0d actual %0d", want.endpoint_slot,
                               o_endpoint_slot);
                        fail_count++;
                    end
                    if (o_offset_in_descriptor !== want.offset_in_descriptor) begin
                        $error("offset_in_descriptor: expected %0d actual %0d",
                               want.offset_in_descriptor, o_offset_in_descriptor);
                        fail_count++;
                    end
                    if (o_config_end !== want.config_end) begin
                        $error("config_end: expected %0b actual %0b", want.config_end,
                               o_config_end);
                        fail_count++;
                    end
                    if (o_run_last !== want.run_last) begin
                        $error("run_last: expected %0b actual %0b", want.run_last, o_run_last);
                        fail_count++;
                    end
                end
            end
            if (!hold_done && beats_seen >= 40) begin
                hold_done = 1'b1;
                hold_left = 400;
            end
            mode_cycles++;
            if (mode_cycles >= 64) begin
                mode_cycles = 0;
                pop_mode = (pop_mode + 1) % 4;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                case (pop_mode)
                    0: i_pop <= 1'b1;
                    1: i_pop <= mode_cycles[0];
                    2: i_pop <= ($urandom_range(0, 9) < 3);
                    default: i_pop <= ((mode_cycles % 5) != 2);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // end of run
    initial begin
        @(posedge i_rst_n);
        while (stream_bytes.size() > 0 || expected_tags.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && expected_tags.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
